// File: hw/rtl/i2p_pkg.sv
// Shared types, character codes and helper functions for the infix to postfix converter.
package i2p_pkg;

	// Request payloads
	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_expression;
	} in_t;

	typedef struct packed {
		logic [7:0] out_symbol;
		logic       symbol_valid;
		logic       out_last;
		logic [1:0] error_code;
	} out_t;

	// ASCII characters of interest
	localparam logic [7:0] CH_ADD  = 8'h2B;
	localparam logic [7:0] CH_SUB  = 8'h2D;
	localparam logic [7:0] CH_MUL  = 8'h2A;
	localparam logic [7:0] CH_DIV  = 8'h2F;
	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_NUL  = 8'h00;

	// Stack entry codes
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_LPAR = 3'd5;

	// Error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_PAREN    = 2'd2;
	localparam logic [1:0] ERR_CHAR     = 2'd3;

	// Character classes
	localparam logic [2:0] CLS_ALNUM = 3'd0;
	localparam logic [2:0] CLS_LPAR  = 3'd1;
	localparam logic [2:0] CLS_RPAR  = 3'd2;
	localparam logic [2:0] CLS_OP    = 3'd3;
	localparam logic [2:0] CLS_BAD   = 3'd4;

	// Output source select
	localparam logic [1:0] SRC_SYM  = 2'd0;
	localparam logic [1:0] SRC_TOP  = 2'd1;
	localparam logic [1:0] SRC_MARK = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       load;
		logic       emit;
		logic [1:0] src;
		logic       last;
		logic [1:0] mark_err;
		logic       push;
		logic       pop;
		logic       set_err;
		logic [1:0] err_code;
		logic       clear;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [2:0] cls;
		logic       pop_ok;
		logic       top_lpar;
		logic       below_lpar;
		logic       sp_zero;
		logic       sp_one;
		logic       sp_two;
		logic       lpar_none;
		logic [1:0] err;
		logic       emit_ok;
		logic       eoe;
	} sts_t;

	function automatic logic [2:0] class_of(input logic [7:0] s);
		logic [2:0] c;
		case (s) inside
			[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]: c = CLS_ALNUM;
			CH_LPAR: c = CLS_LPAR;
			CH_RPAR: c = CLS_RPAR;
			CH_ADD, CH_SUB, CH_MUL, CH_DIV: c = CLS_OP;
			default: c = CLS_BAD;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] code_of(input logic [7:0] s);
		logic [2:0] c;
		case (s)
			CH_ADD:  c = OP_ADD;
			CH_SUB:  c = OP_SUB;
			CH_MUL:  c = OP_MUL;
			CH_DIV:  c = OP_DIV;
			CH_LPAR: c = OP_LPAR;
			default: c = OP_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] rank_of(input logic [2:0] code);
		logic [1:0] r;
		case (code)
			OP_ADD, OP_SUB: r = 2'd1;
			OP_MUL, OP_DIV: r = 2'd2;
			default:        r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] char_of(input logic [2:0] code);
		logic [7:0] c;
		case (code)
			OP_ADD:  c = CH_ADD;
			OP_SUB:  c = CH_SUB;
			OP_MUL:  c = CH_MUL;
			OP_DIV:  c = CH_DIV;
			OP_LPAR: c = CH_LPAR;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

// File: hw/rtl/i2p_dp.sv
// Datapath: input latch, operator stack memory, pointers, error latch and output register.
module i2p_dp #(
	parameter int STACK_DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  i2p_pkg::in_t  in_data,
	input  i2p_pkg::cmd_t cmd,
	output i2p_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_ready,
	output i2p_pkg::out_t out_data
);

	localparam int IW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SPW = $clog2(STACK_DEPTH + 1);

	logic [7:0]     sym_q;
	logic           eoe_q;
	logic [SPW-1:0] sp_q;
	logic [SPW-1:0] sp_next;
	logic [SPW-1:0] rd_ofs;
	logic [IW-1:0]  rd_idx;
	logic [SPW-1:0] lp_q;
	logic [1:0]     err_q;
	logic [2:0]     top_q;
	logic [2:0]     below_q;
	logic [2:0]     mem [STACK_DEPTH];
	logic [2:0]     push_code;
	logic           full;
	logic           push_ok;
	logic           out_valid_q;
	i2p_pkg::out_t  out_q;
	i2p_pkg::out_t  emit_data;

	assign push_code = i2p_pkg::code_of(sym_q);
	assign full      = (sp_q == SPW'(STACK_DEPTH));
	assign push_ok   = cmd.push && !full;

	// Next stack pointer; the memory read follows it so below_q tracks the second entry
	always_comb begin
		sp_next = sp_q;
		if (cmd.clear) begin
			sp_next = '0;
		end else if (push_ok) begin
			sp_next = sp_q + SPW'(1);
		end else if (cmd.pop) begin
			sp_next = sp_q - SPW'(1);
		end
	end

	assign rd_ofs = sp_next - SPW'(2);
	assign rd_idx = rd_ofs[IW-1:0];

	// Input latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sym_q <= in_data.symbol;
			eoe_q <= in_data.end_of_expression;
		end
	end

	// Stack memory with registered read; top of stack held in a register
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[sp_q[IW-1:0]] <= push_code;
		end
		below_q <= mem[rd_idx];
		if (push_ok) begin
			top_q <= push_code;
		end else if (cmd.pop) begin
			top_q <= below_q;
		end
	end

	// Pointer, open-paren count and error latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= '0;
			lp_q  <= '0;
			err_q <= i2p_pkg::ERR_NONE;
		end else begin
			sp_q <= sp_next;
			if (cmd.clear) begin
				lp_q <= '0;
			end else if (push_ok && push_code == i2p_pkg::OP_LPAR) begin
				lp_q <= lp_q + SPW'(1);
			end else if (cmd.pop && top_q == i2p_pkg::OP_LPAR) begin
				lp_q <= lp_q - SPW'(1);
			end
			if (cmd.clear) begin
				err_q <= i2p_pkg::ERR_NONE;
			end else if (cmd.set_err) begin
				err_q <= cmd.err_code;
			end else if (cmd.push && full) begin
				err_q <= i2p_pkg::ERR_OVERFLOW;
			end
		end
	end

	// Result formatting
	always_comb begin
		emit_data = '0;
		case (cmd.src)
			i2p_pkg::SRC_SYM: begin
				emit_data.out_symbol   = sym_q;
				emit_data.symbol_valid = 1'b1;
			end
			i2p_pkg::SRC_TOP: begin
				emit_data.out_symbol   = i2p_pkg::char_of(top_q);
				emit_data.symbol_valid = 1'b1;
			end
			default: begin
				emit_data.out_symbol   = i2p_pkg::CH_NUL;
				emit_data.symbol_valid = 1'b0;
				emit_data.error_code   = cmd.mark_err;
			end
		endcase
		emit_data.out_last = cmd.last;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= emit_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Status to the controller
	always_comb begin
		sts            = '0;
		sts.cls        = i2p_pkg::class_of(sym_q);
		sts.sp_zero    = (sp_q == '0);
		sts.sp_one     = (sp_q == SPW'(1));
		sts.sp_two     = (sp_q == SPW'(2));
		sts.pop_ok     = !sts.sp_zero &&
			(i2p_pkg::rank_of(push_code) <= i2p_pkg::rank_of(top_q));
		sts.top_lpar   = (top_q == i2p_pkg::OP_LPAR);
		sts.below_lpar = (below_q == i2p_pkg::OP_LPAR);
		sts.lpar_none  = (lp_q == '0);
		sts.err        = err_q;
		sts.emit_ok    = !out_valid_q || out_ready;
		sts.eoe        = eoe_q;
	end

endmodule

// File: hw/rtl/i2p_ctrl.sv
// Controller: sequences accept, per-character work, stack pops and the end-of-expression flush.
module i2p_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  i2p_pkg::sts_t sts,
	output i2p_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_END  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic [1:0] after;
	logic       emitted_q;

	assign after = sts.eoe ? ST_END : ST_IDLE;

	// Next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.err != i2p_pkg::ERR_NONE) begin
					state_nxt = after;
				end else begin
					case (sts.cls)
						i2p_pkg::CLS_ALNUM: begin
							if (sts.emit_ok) begin
								cmd.emit  = 1'b1;
								cmd.src   = i2p_pkg::SRC_SYM;
								cmd.last  = sts.eoe && sts.sp_zero;
								state_nxt = after;
							end
						end
						i2p_pkg::CLS_LPAR: begin
							cmd.push  = 1'b1;
							state_nxt = after;
						end
						i2p_pkg::CLS_RPAR: begin
							if (!sts.sp_zero && !sts.top_lpar) begin
								// pop down to the open paren; the last pop may end the output
								if (sts.emit_ok) begin
									cmd.emit = 1'b1;
									cmd.src  = i2p_pkg::SRC_TOP;
									cmd.pop  = 1'b1;
									cmd.last = sts.eoe && sts.sp_two && sts.below_lpar;
								end
							end else if (sts.sp_zero) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = i2p_pkg::ERR_PAREN;
								state_nxt    = after;
							end else begin
								cmd.pop   = 1'b1;
								state_nxt = after;
							end
						end
						i2p_pkg::CLS_OP: begin
							if (sts.pop_ok) begin
								if (sts.emit_ok) begin
									cmd.emit = 1'b1;
									cmd.src  = i2p_pkg::SRC_TOP;
									cmd.pop  = 1'b1;
								end
							end else begin
								cmd.push  = 1'b1;
								state_nxt = after;
							end
						end
						default: begin
							cmd.set_err  = 1'b1;
							cmd.err_code = i2p_pkg::ERR_CHAR;
							state_nxt    = after;
						end
					endcase
				end
			end
			ST_END: begin
				if (sts.err != i2p_pkg::ERR_NONE || !sts.lpar_none) begin
					// error marker; an open paren left on the stack counts as unmatched
					if (sts.emit_ok) begin
						cmd.emit     = 1'b1;
						cmd.src      = i2p_pkg::SRC_MARK;
						cmd.mark_err = (sts.err != i2p_pkg::ERR_NONE) ? sts.err
							: i2p_pkg::ERR_PAREN;
						cmd.last     = 1'b1;
						cmd.clear    = 1'b1;
						state_nxt    = ST_IDLE;
					end
				end else if (!sts.sp_zero) begin
					// flush, one operator per cycle while the output can take it
					if (sts.emit_ok) begin
						cmd.emit = 1'b1;
						cmd.src  = i2p_pkg::SRC_TOP;
						cmd.pop  = 1'b1;
						cmd.last = sts.sp_one;
						if (sts.sp_one) begin
							cmd.clear = 1'b1;
							state_nxt = ST_IDLE;
						end
					end
				end else if (!emitted_q) begin
					if (sts.emit_ok) begin
						cmd.emit     = 1'b1;
						cmd.src      = i2p_pkg::SRC_MARK;
						cmd.mark_err = i2p_pkg::ERR_NONE;
						cmd.last     = 1'b1;
						cmd.clear    = 1'b1;
						state_nxt    = ST_IDLE;
					end
				end else begin
					cmd.clear = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and per-request output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			emitted_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				emitted_q <= 1'b0;
			end else if (cmd.emit) begin
				emitted_q <= 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/infix_to_postfix_converter_unit.sv
// Top level of the shunting-yard infix to postfix converter.
//
//  channel | handshake           | payload              | direction
//  in      | in_valid / in_ready | in_data  (in_t)      | one character request
//  out     | out_valid/out_ready | out_data (out_t)     | one postfix result request
//
// A character is accepted in ST_IDLE and executed in ST_EXEC, where the
// controller pops one stack entry per cycle while the output can take it.
// After the last character, ST_END flushes the remaining operators, or emits
// a bare end marker when that character produced no output.
// Reset clears the pointers and error latch; stack contents stay undefined.
// A full output register stalls the controller in place until it drains.
module infix_to_postfix_converter_unit #(
	parameter int STACK_DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  i2p_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output i2p_pkg::out_t out_data
);

	i2p_pkg::cmd_t cmd;
	i2p_pkg::sts_t sts;

	// Sequencer
	i2p_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Stack and output datapath
	i2p_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: hw/rtl/i2p_chk.sv
// Port-level checker for the converter and its bind to the top level.
module i2p_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input i2p_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input i2p_pkg::out_t out_data
);

	// A stalled character request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request changed while stalled");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// One character at a time: no accept in the cycle after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request accepted back to back");

	// A bare marker always closes the expression
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.symbol_valid |-> out_data.out_last)
		else $error("bare marker without last flag");

	// Errors ride only on bare markers, and characters are never NUL
	a_err_on_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.symbol_valid |->
			out_data.error_code == i2p_pkg::ERR_NONE && out_data.out_symbol != i2p_pkg::CH_NUL)
		else $error("character result carries an error or NUL");

endmodule

bind infix_to_postfix_converter_unit i2p_chk u_i2p_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// File: tb/sv/infix_to_postfix_converter_unit_tb.sv
// Self-checking testbench for the shunting-yard infix to postfix converter.
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_tb;

	localparam int STACK_DEPTH = 32;
	localparam int GAP_MAX = 20;
	localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 16;
	localparam int RANDOM_TARGET = 180;
	localparam longint RUN_LIMIT_NS = 20_000_000;

	// Postfix predictor: own copy of the operator stack, pointer and error latch
	class postfix_tracker;
		logic [2:0]      op_stack [STACK_DEPTH];
		int unsigned     sp;
		logic [1:0]      err_latch;
		i2p_pkg::out_t   postfix_due [$];
		int unsigned     step_count;
		int unsigned     fault_count;
		int unsigned     checked_count;

		function new();
			sp = 0;
			err_latch = i2p_pkg::ERR_NONE;
			fault_count = 0;
			checked_count = 0;
		endfunction

		function logic [1:0] op_rank(logic [2:0] code);
			case (code)
				i2p_pkg::OP_ADD, i2p_pkg::OP_SUB: return 2'd1;
				i2p_pkg::OP_MUL, i2p_pkg::OP_DIV: return 2'd2;
				default:                          return 2'd0;
			endcase
		endfunction

		function logic [7:0] op_char(logic [2:0] code);
			case (code)
				i2p_pkg::OP_ADD:  return i2p_pkg::CH_ADD;
				i2p_pkg::OP_SUB:  return i2p_pkg::CH_SUB;
				i2p_pkg::OP_MUL:  return i2p_pkg::CH_MUL;
				i2p_pkg::OP_DIV:  return i2p_pkg::CH_DIV;
				i2p_pkg::OP_LPAR: return i2p_pkg::CH_LPAR;
				default:          return i2p_pkg::CH_NUL;
			endcase
		endfunction

		function void queue_result(logic [7:0] s, logic v, logic l, logic [1:0] e);
			i2p_pkg::out_t r;
			r.out_symbol = s;
			r.symbol_valid = v;
			r.out_last = l;
			r.error_code = e;
			postfix_due.push_back(r);
			step_count++;
		endfunction

		function void pop_operator();
			queue_result(op_char(op_stack[sp - 1]), 1'b1, 1'b0, i2p_pkg::ERR_NONE);
			sp--;
		endfunction

		function void push_operator(logic [2:0] code);
			if (sp >= STACK_DEPTH) begin
				err_latch = i2p_pkg::ERR_OVERFLOW;
			end else begin
				op_stack[sp] = code;
				sp++;
			end
		endfunction

		// Predict the results of one accepted request; returns 0 if it is ignored
		function bit absorb_char(i2p_pkg::in_t req);
			logic [7:0]    sym;
			logic [2:0]    code;
			bit            live;
			i2p_pkg::out_t r;
			int unsigned   i;
			sym = req.symbol;
			step_count = 0;
			live = (err_latch == i2p_pkg::ERR_NONE) || req.end_of_expression;
			case (sym)
				i2p_pkg::CH_ADD: code = i2p_pkg::OP_ADD;
				i2p_pkg::CH_SUB: code = i2p_pkg::OP_SUB;
				i2p_pkg::CH_MUL: code = i2p_pkg::OP_MUL;
				i2p_pkg::CH_DIV: code = i2p_pkg::OP_DIV;
				default:         code = i2p_pkg::OP_NONE;
			endcase

			if (err_latch == i2p_pkg::ERR_NONE) begin
				if ((sym >= "0" && sym <= "9") || (sym >= "A" && sym <= "Z") ||
						(sym >= "a" && sym <= "z")) begin
					queue_result(sym, 1'b1, 1'b0, i2p_pkg::ERR_NONE);
				end else if (sym == i2p_pkg::CH_LPAR) begin
					push_operator(i2p_pkg::OP_LPAR);
				end else if (sym == i2p_pkg::CH_RPAR) begin
					while (sp > 0 && op_stack[sp - 1] != i2p_pkg::OP_LPAR)
						pop_operator();
					if (sp == 0)
						err_latch = i2p_pkg::ERR_PAREN;
					else
						sp--;
				end else if (code != i2p_pkg::OP_NONE) begin
					while (sp > 0 && op_rank(code) <= op_rank(op_stack[sp - 1]))
						pop_operator();
					push_operator(code);
				end else begin
					err_latch = i2p_pkg::ERR_CHAR;
				end
			end

			// End of expression: check for open '(' then flush or mark the error
			if (req.end_of_expression) begin
				if (err_latch == i2p_pkg::ERR_NONE)
					for (i = 0; i < sp; i++)
						if (op_stack[i] == i2p_pkg::OP_LPAR)
							err_latch = i2p_pkg::ERR_PAREN;
				if (err_latch != i2p_pkg::ERR_NONE) begin
					queue_result(i2p_pkg::CH_NUL, 1'b0, 1'b1, err_latch);
				end else begin
					while (sp > 0)
						pop_operator();
					if (step_count == 0) begin
						queue_result(i2p_pkg::CH_NUL, 1'b0, 1'b1, i2p_pkg::ERR_NONE);
					end else begin
						r = postfix_due.pop_back();
						r.out_last = 1'b1;
						postfix_due.push_back(r);
					end
				end
				sp = 0;
				err_latch = i2p_pkg::ERR_NONE;
			end
			return live;
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t ns: %s", $time, msg);
			fault_count++;
		endtask

		// Compare one accepted result with the oldest expected one
		task check_postfix(i2p_pkg::out_t got);
			i2p_pkg::out_t want;
			if (postfix_due.size() == 0) begin
				report($sformatf("unexpected result sym=0x%02h valid=%0b last=%0b err=%0d",
					got.out_symbol, got.symbol_valid, got.out_last, got.error_code));
			end else begin
				want = postfix_due.pop_front();
				checked_count++;
				if (got.out_symbol !== want.out_symbol)
					report($sformatf("out_symbol got 0x%02h expected 0x%02h",
						got.out_symbol, want.out_symbol));
				if (got.symbol_valid !== want.symbol_valid)
					report($sformatf("symbol_valid got %0b expected %0b",
						got.symbol_valid, want.symbol_valid));
				if (got.out_last !== want.out_last)
					report($sformatf("out_last got %0b expected %0b",
						got.out_last, want.out_last));
				if (got.error_code !== want.error_code)
					report($sformatf("error_code got %0d expected %0d",
						got.error_code, want.error_code));
			end
		endtask

		function int unsigned pending();
			return postfix_due.size();
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	i2p_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	i2p_pkg::out_t out_data;

	int send_idle_pct = 38;
	int recv_idle_pct = 74;

	i2p_pkg::in_t char_stream [$];
	logic [7:0]   expr_chars [$];
	int unsigned  req_count = 0;
	int unsigned  expr_count = 0;

	postfix_tracker tracker = new();

	infix_to_postfix_converter_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Timeout: results still outstanding at the run limit");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Monitor: predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				void'(tracker.absorb_char(in_data));
				req_count++;
				if (in_data.end_of_expression)
					expr_count++;
			end
			if (out_valid && out_ready)
				tracker.check_postfix(out_data);
		end
	end

	function automatic int idle_gap(int pct);
		int gap;
		gap = 0;
		while (gap < GAP_MAX && $urandom_range(0, 99) < pct)
			gap++;
		return gap;
	endfunction

	function automatic logic [7:0] rand_alnum();
		case ($urandom_range(0, 2))
			0:       return 8'h30 + 8'($urandom_range(0, 9));
			1:       return 8'h41 + 8'($urandom_range(0, 25));
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(0, 3))
			0:       return i2p_pkg::CH_ADD;
			1:       return i2p_pkg::CH_SUB;
			2:       return i2p_pkg::CH_MUL;
			default: return i2p_pkg::CH_DIV;
		endcase
	endfunction

	// Move the pending characters into the stream, end flag on the last one
	task automatic commit_expr();
		i2p_pkg::in_t req;
		int           i;
		for (i = 0; i < expr_chars.size(); i++) begin
			req.symbol = expr_chars[i];
			req.end_of_expression = (i == expr_chars.size() - 1);
			char_stream.push_back(req);
		end
		expr_chars.delete();
	endtask

	task automatic add_text(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			expr_chars.push_back(s[i]);
	endtask

	// Balanced expression with random operands, operators and nesting
	task automatic build_wellformed();
		int n_operands;
		int depth;
		int i;
		n_operands = $urandom_range(1, 6);
		depth = 0;
		for (i = 0; i < n_operands; i++) begin
			while (depth < 5 && $urandom_range(0, 3) == 0) begin
				expr_chars.push_back(i2p_pkg::CH_LPAR);
				depth++;
			end
			expr_chars.push_back(rand_alnum());
			while (depth > 0 && $urandom_range(0, 2) == 0) begin
				expr_chars.push_back(i2p_pkg::CH_RPAR);
				depth--;
			end
			if (i < n_operands - 1)
				expr_chars.push_back(rand_op());
		end
		while (depth > 0) begin
			expr_chars.push_back(i2p_pkg::CH_RPAR);
			depth--;
		end
	endtask

	// Well-formed expression with one character spoiled or an extra ')' inserted
	task automatic build_broken();
		int pos;
		build_wellformed();
		pos = $urandom_range(0, expr_chars.size() - 1);
		case ($urandom_range(0, 3))
			0:       expr_chars[pos] = 8'($urandom_range(0, 255));
			1:       expr_chars[pos] = i2p_pkg::CH_LPAR;
			2:       expr_chars[pos] = i2p_pkg::CH_RPAR;
			default: expr_chars.insert(pos, i2p_pkg::CH_RPAR);
		endcase
	endtask

	task automatic build_stimulus();
		int kind;
		// Directed: precedence, parens, stray close, open at end, bad chars, empty output
		add_text("a+b*c");
		commit_expr();
		add_text("(Z-0)/9");
		commit_expr();
		add_text(")");
		commit_expr();
		add_text("(");
		commit_expr();
		expr_chars.push_back("a");
		expr_chars.push_back(8'hFF);
		expr_chars.push_back("b");
		commit_expr();
		expr_chars.push_back(i2p_pkg::CH_NUL);
		commit_expr();
		add_text("()");
		commit_expr();
		add_text("a*b)");
		commit_expr();

		// Full stack: an operator push overflows, then a '(' push overflows
		repeat (STACK_DEPTH - 1) expr_chars.push_back(i2p_pkg::CH_LPAR);
		expr_chars.push_back(rand_alnum());
		expr_chars.push_back(i2p_pkg::CH_ADD);
		expr_chars.push_back(rand_alnum());
		expr_chars.push_back(i2p_pkg::CH_MUL);
		expr_chars.push_back(rand_alnum());
		commit_expr();
		repeat (STACK_DEPTH) expr_chars.push_back(i2p_pkg::CH_LPAR);
		expr_chars.push_back(rand_alnum());
		expr_chars.push_back(i2p_pkg::CH_LPAR);
		commit_expr();

		// Random mix, mostly well-formed, until the stream holds the target count
		while (char_stream.size() < RANDOM_TARGET) begin
			kind = $urandom_range(0, 99);
			if (kind < 60)
				build_wellformed();
			else if (kind < 80)
				build_broken();
			else
				repeat ($urandom_range(1, 6)) expr_chars.push_back(8'($urandom_range(0, 255)));
			commit_expr();
		end
	endtask

	initial begin
		int phase;
		int gap;
		int guard;
		build_stimulus();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Send every request; pacing changes over thirds of the stream
		foreach (char_stream[i]) begin
			phase = (i * 3) / char_stream.size();
			case (phase)
				0: begin
					send_idle_pct = 38;
					recv_idle_pct = 74;
				end
				1: begin
					send_idle_pct = 74;
					recv_idle_pct = 38;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			gap = idle_gap(send_idle_pct);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_data <= char_stream[i];
			@(posedge clk);
			while (!in_ready) @(posedge clk);
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then watch for strays
		guard = 0;
		while (tracker.pending() > 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.pending() > 0)
			tracker.report($sformatf("%0d expected results never arrived", tracker.pending()));

		$display("Covered %0d character requests in %0d expressions, %0d postfix results checked",
			req_count, expr_count, tracker.checked_count);
		$display("Pacing 38/74, 74/38 and 0/0 percent idle; overflow, paren and bad-char cases hit");
		if (tracker.fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
